// ----- rtl/sps_pkg.sv -----
// Shared types, constants and phase tables for the stepper phase sequencer.
// Used by sps_step and stepper_phase_sequencer_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

	// Sequencer geometry.
	localparam int PHASES         = 8;
	localparam int STEPS_PER_UNIT = 12;
	localparam int PHASE_W        = 3;
	// The accumulator must hold +-STEPS_PER_UNIT just before it clears.
	localparam int ACC_W          = $clog2(STEPS_PER_UNIT + 1) + 1;

	// Field widths.
	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 14;
	localparam int COIL_W   = 4;
	localparam int AZ_W     = 16;
	localparam int ELEV_W   = 14;
	localparam int PERIOD_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;
	localparam int OUT_DATA_W = 40;

	// Command codes.
	localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_STOP       = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TURN_LEFT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_TURN_RIGHT = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SET_ELEV   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POWER_SAVE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ELEV_MIN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELEV_MAX    = 2'd3;

	// Reset values.
	localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 8'd100;
	localparam logic [ELEV_W-1:0]   ELEV_MIN_RST    = 14'd500;
	localparam logic [ELEV_W-1:0]   ELEV_MAX_RST    = 14'd1000;
	localparam logic [ELEV_W-1:0]   ELEV_RST        = 14'd750;

	// Motor position state that a step updates.
	typedef struct packed {
		logic [PHASE_W-1:0]       phase;
		logic signed [ACC_W-1:0]  accum;
		logic [COIL_W-1:0]        coil;
		logic [AZ_W-1:0]          azimuth;
	} sps_motor_t;

	// One result word.
	typedef struct packed {
		logic [ELEV_W-1:0] elevation_compare;
		logic [AZ_W-1:0]   azimuth;
		logic              step_taken;
		logic              running;
		logic [COIL_W-1:0] coil_drive;
	} sps_result_t;

	typedef logic [COIL_W-1:0] coil_tab_t [8];

	localparam coil_tab_t HALF_STEP_TAB = '{4'h7, 4'h3, 4'hb, 4'h9, 4'hd, 4'hc, 4'he, 4'h6};
	localparam coil_tab_t WAVE_TAB      = '{4'h7, 4'hb, 4'hd, 4'he, 4'h7, 4'hb, 4'hd, 4'he};

endpackage
`default_nettype wire

// ----- rtl/sps_step.sv -----
// Next motor position for one step: coil pattern, phase index, step
// accumulator and azimuth. Uses types and tables from sps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sps_step (
	input  wire logic              power_save,
	input  wire logic              forward,
	input  wire sps_pkg::sps_motor_t cur,
	output sps_pkg::sps_motor_t    nxt
);

	localparam logic [sps_pkg::PHASE_W-1:0] LAST_PHASE =
		sps_pkg::PHASE_W'(sps_pkg::PHASES - 1);
	localparam logic signed [sps_pkg::ACC_W-1:0] ACC_LIMIT =
		sps_pkg::ACC_W'(sps_pkg::STEPS_PER_UNIT - 1);

	logic signed [sps_pkg::ACC_W-1:0] acc_moved;
	logic [sps_pkg::AZ_W-1:0]         az_inc;

	always_comb begin
		az_inc = power_save ? sps_pkg::AZ_W'(1) : sps_pkg::AZ_W'(2);
		nxt = cur;
		// The pattern sent out is the one at the phase before it moves.
		nxt.coil = power_save ? sps_pkg::HALF_STEP_TAB[cur.phase] :
			sps_pkg::WAVE_TAB[cur.phase];
		if (forward) begin
			nxt.phase = (cur.phase >= LAST_PHASE) ? '0 : cur.phase + 1'b1;
			acc_moved = cur.accum + sps_pkg::ACC_W'(1);
		end else begin
			nxt.phase = (cur.phase == '0 || cur.phase > LAST_PHASE) ? LAST_PHASE :
				cur.phase - 1'b1;
			acc_moved = cur.accum - sps_pkg::ACC_W'(1);
		end
		nxt.accum = acc_moved;
		if (acc_moved < -ACC_LIMIT) begin
			nxt.accum   = '0;
			nxt.azimuth = cur.azimuth - az_inc;
		end else if (acc_moved > ACC_LIMIT) begin
			nxt.accum   = '0;
			nxt.azimuth = cur.azimuth + az_inc;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/stepper_phase_sequencer_unit.sv -----
// Stepper motor phase sequencer: top level. Depends on sps_pkg and sps_step.
// A result word is registered in the output register, or in the skid stage
// if that is held, as its command word is accepted. One word per cycle while
// the skid stage is empty. A two-entry output register and skid stage keep
// the slave side open while one result waits. Reset (arst_n low) stops the
// motor, clears the coils, counters and azimuth and loads the defaults.
`timescale 1ns / 1ps
`default_nettype none
module stepper_phase_sequencer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Command stream.
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [15:0]                       s_axis_tdata,  // [13:0] value, rest zero
	input  wire logic [sps_pkg::OPCODE_W-1:0]      s_axis_tuser,  // [2:0] opcode
	// Result stream.
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [3:0] coil_drive, [4] running, [5] step_taken, [21:6] azimuth,
	// [35:22] elevation_compare, [39:36] zero
	output logic [sps_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

	// Configuration registers.
	logic                             power_save_q;
	logic [sps_pkg::PERIOD_W-1:0]     step_period_q;
	logic [sps_pkg::ELEV_W-1:0]       elev_min_q;
	logic [sps_pkg::ELEV_W-1:0]       elev_max_q;

	// Sequencer state.
	logic [sps_pkg::PERIOD_W-1:0]     tick_count_q;
	logic                             running_q;
	logic                             forward_q;
	sps_pkg::sps_motor_t              motor_q;
	logic [sps_pkg::ELEV_W-1:0]       elev_q;

	// Output register and skid stage.
	logic                             out_valid_q;
	sps_pkg::sps_result_t             out_data_q;
	logic                             skid_valid_q;
	sps_pkg::sps_result_t             skid_data_q;

	logic                             accept;
	logic [sps_pkg::VALUE_W-1:0]      value;
	sps_pkg::sps_motor_t              motor_stepped;

	logic [sps_pkg::PERIOD_W-1:0]     tick_count_d;
	logic                             running_d;
	logic                             forward_d;
	sps_pkg::sps_motor_t              motor_d;
	logic [sps_pkg::ELEV_W-1:0]       elev_d;
	logic                             stepped_d;
	sps_pkg::sps_result_t             result_d;

	assign value  = s_axis_tdata[sps_pkg::VALUE_W-1:0];
	assign accept = s_axis_tvalid && s_axis_tready;

	// The step logic sees the present position and direction; its output is
	// used only when a tick hits the compare value while running.
	sps_step u_step (
		.power_save (power_save_q),
		.forward    (forward_q),
		.cur        (motor_q),
		.nxt        (motor_stepped)
	);

	// Next state for the command word on the slave side.
	always_comb begin
		tick_count_d = tick_count_q;
		running_d    = running_q;
		forward_d    = forward_q;
		motor_d      = motor_q;
		elev_d       = elev_q;
		stepped_d    = 1'b0;
		case (s_axis_tuser)
			sps_pkg::OP_TICK: begin
				// A stopped timer holds its count. The compare is an equality,
				// so a count above a lowered period runs on and wraps first.
				if (running_q) begin
					if (tick_count_q == step_period_q) begin
						tick_count_d = '0;
						motor_d      = motor_stepped;
						stepped_d    = 1'b1;
					end else begin
						tick_count_d = tick_count_q + 1'b1;
					end
				end
			end
			sps_pkg::OP_STOP: begin
				// Counter, phase, accumulator and direction are kept.
				running_d    = 1'b0;
				motor_d.coil = '0;
			end
			sps_pkg::OP_TURN_LEFT: begin
				running_d = 1'b1;
				forward_d = 1'b1;
			end
			sps_pkg::OP_TURN_RIGHT: begin
				running_d = 1'b1;
				forward_d = 1'b0;
			end
			sps_pkg::OP_SET_ELEV: begin
				// Out-of-window requests are dropped; an empty window drops all.
				if (value >= elev_min_q && value <= elev_max_q) begin
					elev_d = value;
				end
			end
			default: begin
			end
		endcase

		result_d.coil_drive        = motor_d.coil;
		result_d.running           = running_d;
		result_d.step_taken        = stepped_d;
		result_d.azimuth           = motor_d.azimuth;
		result_d.elevation_compare = elev_d;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_save_q  <= 1'b0;
			step_period_q <= sps_pkg::STEP_PERIOD_RST;
			elev_min_q    <= sps_pkg::ELEV_MIN_RST;
			elev_max_q    <= sps_pkg::ELEV_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sps_pkg::REG_POWER_SAVE:  power_save_q  <= cfg_data[0];
				sps_pkg::REG_STEP_PERIOD: step_period_q <= cfg_data[sps_pkg::PERIOD_W-1:0];
				sps_pkg::REG_ELEV_MIN:    elev_min_q    <= cfg_data[sps_pkg::ELEV_W-1:0];
				sps_pkg::REG_ELEV_MAX:    elev_max_q    <= cfg_data[sps_pkg::ELEV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer state advances once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			running_q    <= 1'b0;
			forward_q    <= 1'b1;
			motor_q      <= '0;
			elev_q       <= sps_pkg::ELEV_RST;
		end else if (accept) begin
			tick_count_q <= tick_count_d;
			running_q    <= running_d;
			forward_q    <= forward_d;
			motor_q      <= motor_d;
			elev_q       <= elev_d;
		end
	end

	// The slave side stays open until the skid stage holds a word.
	assign s_axis_tready = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(sps_pkg::OUT_DATA_W - $bits(sps_pkg::sps_result_t)){1'b0}},
		out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			// Output register is free this cycle: the skid word goes first.
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= accept;
			end else begin
				out_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_data_q  <= skid_data_q;
				skid_data_q <= result_d;
			end else begin
				out_data_q  <= result_d;
			end
		end else if (accept) begin
			skid_data_q <= result_d;
		end
	end

endmodule
`default_nettype wire

// ----- tb/sps_result_checker.sv -----
// Checker for the stepper phase sequencer: follows the command and result
// streams, predicts every result word and compares it field by field.
// Depends on sps_pkg for the command codes, register indexes and word layout.
`timescale 1ns / 1ps
module sps_result_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           cmd_tvalid,
	input  wire logic                           cmd_tready,
	input  wire logic [15:0]                    cmd_tdata,  // [13:0] value, rest zero
	input  wire logic [sps_pkg::OPCODE_W-1:0]   cmd_tuser,  // [2:0] opcode
	input  wire logic                           res_tvalid,
	input  wire logic                           res_tready,
	// [3:0] coil_drive, [4] running, [5] step_taken, [21:6] azimuth,
	// [35:22] elevation_compare, [39:36] zero
	input  wire logic [sps_pkg::OUT_DATA_W-1:0] res_tdata,
	output int                                  mismatches,
	output int                                  words_owed
);
	import sps_pkg::*;

	// Coil patterns, entry 0 in the lowest nibble.
	localparam logic [31:0] HALF_STEP_COILS = {4'h6, 4'he, 4'hc, 4'hd, 4'h9, 4'hb, 4'h3, 4'h7};
	localparam logic [31:0] WAVE_COILS      = {4'he, 4'hd, 4'hb, 4'h7, 4'he, 4'hd, 4'hb, 4'h7};
	localparam int          LAST_PHASE      = 7;
	// Twelve steps one way move the azimuth by one unit.
	localparam logic signed [4:0] ACC_TURN  = 5'sd11;
	localparam int          REPORT_CAP      = 40;

	// Copy of the configuration registers.
	logic        power_save;
	logic [7:0]  period;
	logic [13:0] elev_lo;
	logic [13:0] elev_hi;

	// Copy of the motor state.
	logic [7:0]         tick_cnt;
	logic               running;
	logic               forward;
	logic [2:0]         phase;
	logic signed [4:0]  accum;
	logic [3:0]         coils;
	logic [15:0]        az;
	logic [13:0]        elev;

	sps_result_t predicted_words[$];

	// Later mismatches are still counted but no longer printed.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < REPORT_CAP)
			$display("checker: %s wrong at %0t ns: got %0h, predicted %0h",
				what, $time, got, want);
		mismatches++;
	endtask

	// Applies one command word to the motor copy and returns the word that the
	// block should report afterwards.
	function automatic sps_result_t predict_word(input logic [2:0] op, input logic [13:0] val);
		logic        stepped;
		sps_result_t w;
		stepped = 1'b0;
		case (op)
			OP_TICK: begin
				if (running) begin
					if (tick_cnt == period) begin
						tick_cnt = '0;
						stepped  = 1'b1;
						coils    = power_save ? HALF_STEP_COILS[phase*4 +: 4]
						                      : WAVE_COILS[phase*4 +: 4];
						if (forward) begin
							phase = (phase >= LAST_PHASE) ? 3'd0 : phase + 3'd1;
							accum = accum + 5'sd1;
						end else begin
							phase = (phase == 3'd0) ? 3'(LAST_PHASE) : phase - 3'd1;
							accum = accum - 5'sd1;
						end
						if (accum < -ACC_TURN) begin
							accum = '0;
							az    = az - (power_save ? 16'd1 : 16'd2);
						end else if (accum > ACC_TURN) begin
							accum = '0;
							az    = az + (power_save ? 16'd1 : 16'd2);
						end
					end else begin
						tick_cnt = tick_cnt + 8'd1;
					end
				end
			end
			OP_STOP: begin
				running = 1'b0;
				coils   = '0;
			end
			OP_TURN_LEFT: begin
				running = 1'b1;
				forward = 1'b1;
			end
			OP_TURN_RIGHT: begin
				running = 1'b1;
				forward = 1'b0;
			end
			OP_SET_ELEV: begin
				if (val >= elev_lo && val <= elev_hi)
					elev = val;
			end
			default: ;
		endcase
		w.coil_drive        = coils;
		w.running           = running;
		w.step_taken        = stepped;
		w.azimuth           = az;
		w.elevation_compare = elev;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sps_result_t got;
		sps_result_t want;
		if (!arst_n) begin
			power_save = 1'b0;
			period     = 8'd100;
			elev_lo    = 14'd500;
			elev_hi    = 14'd1000;
			tick_cnt   = '0;
			running    = 1'b0;
			forward    = 1'b1;
			phase      = '0;
			accum      = '0;
			coils      = '0;
			az         = '0;
			elev       = 14'd750;
			mismatches = 0;
			predicted_words.delete();
			words_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POWER_SAVE:  power_save = cfg_data[0];
					REG_STEP_PERIOD: period     = cfg_data[7:0];
					REG_ELEV_MIN:    elev_lo    = cfg_data[13:0];
					REG_ELEV_MAX:    elev_hi    = cfg_data[13:0];
					default: ;
				endcase
			end
			if (cmd_tvalid && cmd_tready)
				predicted_words.push_back(predict_word(cmd_tuser, cmd_tdata[13:0]));
			if (res_tvalid && res_tready) begin
				got = res_tdata[35:0];
				if (predicted_words.size() == 0) begin
					report_mismatch("word with none pending", got, 0);
				end else begin
					want = predicted_words.pop_front();
					if (got.coil_drive != want.coil_drive)
						report_mismatch("coil_drive", got.coil_drive, want.coil_drive);
					if (got.running != want.running)
						report_mismatch("running", got.running, want.running);
					if (got.step_taken != want.step_taken)
						report_mismatch("step_taken", got.step_taken, want.step_taken);
					if (got.azimuth != want.azimuth)
						report_mismatch("azimuth", got.azimuth, want.azimuth);
					if (got.elevation_compare != want.elevation_compare)
						report_mismatch("elevation_compare", got.elevation_compare,
							want.elevation_compare);
				end
			end
			words_owed <= predicted_words.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// Top of the stepper phase sequencer testbench: clock, reset, command words,
// result back-pressure and the verdict. Depends on sps_pkg,
// stepper_phase_sequencer_unit and sps_result_checker.
`timescale 1ns / 1ps
module tb;
	import sps_pkg::*;

	// Opcodes that the block must ignore.
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam logic [13:0] ELEV_TOP     = 14'd9999;
	localparam int          PHASE_COUNT  = 8;
	localparam int          PHASE_ITEMS  = 105;
	// Length of the one long receiver hold-off, long enough to fill the
	// block's output register and stall its command side.
	localparam int          RX_HOLD_CYCLES = 200;
	// Cycles without any accepted word before the run is declared hung. The
	// longest correct quiet stretch is the hold-off above plus a stall.
	localparam int          STALL_LIMIT    = 2000;

	logic clk;
	logic arst_n = 1'b0;

	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata  = '0;  // [13:0] value, rest zero
	logic [OPCODE_W-1:0]   s_axis_tuser  = '0;  // [2:0] opcode

	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [3:0] coil_drive, [4] running, [5] step_taken, [21:6] azimuth,
	// [35:22] elevation_compare, [39:36] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int mismatches;
	int words_owed;

	// When set, neither side idles; the sender redraws it now and then so
	// that full-rate stretches alternate with ragged ones.
	logic calm = 1'b0;
	// Raised by the sender to ask the receiver for its long hold-off.
	logic rx_hold_req = 1'b0;

	stepper_phase_sequencer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	sps_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_tvalid (s_axis_tvalid),
		.cmd_tready (s_axis_tready),
		.cmd_tdata  (s_axis_tdata),
		.cmd_tuser  (s_axis_tuser),
		.res_tvalid (m_axis_tvalid),
		.res_tready (m_axis_tready),
		.res_tdata  (m_axis_tdata),
		.mismatches (mismatches),
		.words_owed (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length before a word or a ready phase: mostly none or a few
	// cycles, now and then a long gap.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 30);
	endfunction

	// Offers one command word, after an optional gap, and returns at the edge
	// at which it is taken. Valid stays high on return so that a following
	// word can go out back to back.
	task automatic send_word(input logic [2:0] op, input logic [13:0] val);
		int gap;
		gap = idle_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {2'b00, val};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops offering words and waits until every predicted result has been
	// taken. The first edge lets the checker count the last word sent.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (words_owed == 0);
		@(posedge clk);
	endtask

	// Writes all four registers on consecutive edges; the block is idle.
	task automatic load_registers(input logic psave, input logic [7:0] period,
	                              input logic [13:0] lo, input logic [13:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POWER_SAVE;
		cfg_data  <= {13'd0, psave};
		@(posedge clk);
		cfg_index <= REG_STEP_PERIOD;
		cfg_data  <= {6'd0, period};
		@(posedge clk);
		cfg_index <= REG_ELEV_MIN;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_ELEV_MAX;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Receiver: ready toggles in random phases, with one long hold-off on
	// request. Every branch assigns ready and lets time pass after each assignment.
	initial begin : receiver
		int gap;
		wait (arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = idle_gap();
				if (gap != 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: errors");
		$finish;
	end

	initial begin : stimulus
		logic        psave;
		logic [7:0]  period;
		logic [13:0] lo;
		logic [13:0] hi;
		logic [13:0] swap;
		logic [2:0]  op;
		logic [13:0] val;
		int          r;
		int          k;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset: elevation window 500..1000, motor stopped.
		// The window edges are tried from both sides, then a tick and a stop
		// while stopped, then the three unused opcodes.
		send_word(OP_SET_ELEV, 14'd0);
		send_word(OP_SET_ELEV, ELEV_TOP);
		send_word(OP_SET_ELEV, 14'd499);
		send_word(OP_SET_ELEV, 14'd500);
		send_word(OP_SET_ELEV, 14'd1001);
		send_word(OP_SET_ELEV, 14'd1000);
		send_word(OP_TICK, 14'd0);
		send_word(OP_STOP, 14'd0);
		send_word(OP_UNUSED_LO, ELEV_TOP);
		send_word(OP_UNUSED_MID, ELEV_TOP);
		send_word(OP_UNUSED_HI, ELEV_TOP);

		// Half-step table with a step on every tick: turning right wraps the
		// phase from 0 to 7, then left, then a stop that clears the coils, a
		// tick that must not move anything, and a restart that keeps the
		// counter.
		drain_results();
		load_registers(1'b1, 8'd0, 14'd0, ELEV_TOP);
		send_word(OP_TURN_RIGHT, 14'd0);
		repeat (3) send_word(OP_TICK, 14'd0);
		send_word(OP_TURN_LEFT, 14'd0);
		repeat (2) send_word(OP_TICK, 14'd0);
		send_word(OP_STOP, 14'd0);
		send_word(OP_TICK, 14'd0);
		send_word(OP_TURN_LEFT, 14'd0);
		send_word(OP_TICK, 14'd0);

		// With the minimum above the maximum every elevation request fails.
		drain_results();
		load_registers(1'b0, 8'd255, ELEV_TOP, 14'd0);
		send_word(OP_SET_ELEV, 14'd5000);
		send_word(OP_SET_ELEV, 14'd0);

		// Random phases. Each begins with the block drained, so the sender
		// has paused until every result is in before the registers change.
		// The slow period-255 phase leaves the counter high before a short
		// period, so the counter has to run round through 255.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			case (p)
				0: begin psave = 1'b0; period = 8'd0;   lo = 14'd0;    hi = ELEV_TOP; end
				1: begin psave = 1'b1; period = 8'd255; lo = ELEV_TOP; hi = 14'd0;    end
				2: begin psave = 1'b1; period = 8'd2;   lo = 14'd100;  hi = 14'd200;  end
				3: begin psave = 1'b0; period = 8'd1;   lo = 14'd5000; hi = 14'd5000; end
				default: begin
					psave  = 1'($urandom_range(0, 1));
					period = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					                                     : 8'($urandom_range(0, 7));
					lo     = 14'($urandom_range(0, ELEV_TOP));
					hi     = 14'($urandom_range(lo, ELEV_TOP));
					if ($urandom_range(0, 4) == 0) begin
						swap = lo;
						lo   = hi;
						hi   = swap;
					end
				end
			endcase
			load_registers(psave, period, lo, hi);
			// The receiver holds off here while words keep coming.
			if (p == 2)
				rx_hold_req = 1'b1;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// Mostly ticks, with rare turns, so that runs of steps in one
				// direction are long enough to move the azimuth.
				r = $urandom_range(0, 99);
				if (r < 85)
					op = OP_TICK;
				else if (r < 89)
					op = OP_TURN_LEFT;
				else if (r < 92)
					op = OP_TURN_RIGHT;
				else if (r < 94)
					op = OP_STOP;
				else if (r < 99)
					op = OP_SET_ELEV;
				else
					op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				// The value travels with every word; for elevation requests
				// half land inside the window and some just outside it.
				k = $urandom_range(0, 9);
				if (k < 5 && lo <= hi)
					val = 14'($urandom_range(lo, hi));
				else if (k < 8)
					val = 14'($urandom_range(0, ELEV_TOP));
				else if (k == 8)
					val = (lo == 14'd0) ? 14'd0 : lo - 14'd1;
				else
					val = (hi >= ELEV_TOP) ? ELEV_TOP : hi + 14'd1;
				send_word(op, val);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
